### hdl/pbr_pkg.sv
// Shared types and constants for the double-buffered playback frame store.
// No dependencies; imported by pbr_ctrl, ping_pong_audio_buffer_reader, pbr_checker and the bench top.
`timescale 1ns / 1ps
`default_nettype none
package pbr_pkg;

	localparam int STORE_DEPTH = 4096;
	localparam int FRAME_BITS  = 32;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int SIZE_W      = ADDR_W + 1;
	localparam int CFG_W       = 13;
	localparam int CFG_IDX_W   = 2;

	typedef enum logic [2:0] {
		OP_WRITE   = 3'd0,
		OP_READ    = 3'd1,
		OP_RELEASE = 3'd2,
		OP_START   = 3'd3,
		OP_STOP    = 3'd4
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BUFFER_FRAMES = 2'd0,
		REG_STREAM_MODE   = 2'd1,
		REG_LOOPING       = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic valid;
		logic hit;
		logic counted;
		logic half0_done;
		logic half1_done;
		logic playing;
	} pbr_status_t;

endpackage
`default_nettype wire

### hdl/pbr_ctrl.sv
// Playback control: configuration registers, read cursor, half done flags, play state.
// Depends on pbr_pkg; drives the frame store read port of the top level.
`timescale 1ns / 1ps
`default_nettype none
module pbr_ctrl
	import pbr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 accept,
	input  wire logic [2:0]           operation,
	input  wire logic                 half_select,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	output logic                      rd_en,
	output logic [ADDR_W-1:0]         rd_addr,
	output pbr_status_t               status
);

	logic [CFG_W-1:0]  buffer_frames_q;
	logic              stream_mode_q;
	logic              looping_q;
	logic [ADDR_W-1:0] cursor_q;
	logic [1:0]        half_done_q;
	logic              playing_q;
	logic              valid_s1;
	logic              hit_s1;
	logic              counted_s1;

	logic [SIZE_W-1:0] size;
	logic [ADDR_W-1:0] half;
	logic [SIZE_W-1:0] pos;
	logic [SIZE_W-1:0] pos_inc;
	logic              idx;
	logic              at_end;
	logic [ADDR_W-1:0] cursor_d;
	logic [1:0]        half_done_d;
	logic              playing_d;
	logic              hit_d;
	logic              counted_d;

	always_comb begin
		if (buffer_frames_q > CFG_W'(STORE_DEPTH)) begin
			size = SIZE_W'(STORE_DEPTH);
		end else begin
			size = buffer_frames_q[SIZE_W-1:0];
		end
		size[0] = 1'b0;
		if (size < SIZE_W'(2)) begin
			size = SIZE_W'(2);
		end
		half    = size[SIZE_W-1:1];
		pos     = {1'b0, cursor_q};
		pos_inc = pos + SIZE_W'(1);
		idx     = (pos >= {1'b0, half});
		if (stream_mode_q && !idx) begin
			at_end = (pos_inc == {1'b0, half});
		end else begin
			at_end = (pos_inc == size);
		end
	end

	always_comb begin
		cursor_d    = cursor_q;
		half_done_d = half_done_q;
		playing_d   = playing_q;
		hit_d       = 1'b0;
		counted_d   = 1'b0;
		case (op_t'(operation))
			OP_READ: begin
				if (playing_q) begin
					if (pos >= size) begin
						cursor_d = '0;
					end else if (stream_mode_q && half_done_q[idx]) begin
						counted_d = 1'b1;
					end else begin
						hit_d     = 1'b1;
						counted_d = 1'b1;
						cursor_d  = (pos_inc >= size) ? '0 : pos_inc[ADDR_W-1:0];
						if (at_end) begin
							half_done_d[idx] = 1'b1;
							if (!looping_q) begin
								playing_d = 1'b0;
							end
						end
					end
				end
			end
			OP_RELEASE: half_done_d[half_select] = 1'b0;
			OP_START:   playing_d = 1'b1;
			OP_STOP:    playing_d = 1'b0;
			default:    ;
		endcase
	end

	assign rd_en   = accept && hit_d;
	assign rd_addr = cursor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_frames_q <= CFG_W'(STORE_DEPTH);
			stream_mode_q   <= 1'b1;
			looping_q       <= 1'b0;
			cursor_q        <= '0;
			half_done_q     <= 2'b11;
			playing_q       <= 1'b0;
			valid_s1        <= 1'b0;
			hit_s1          <= 1'b0;
			counted_s1      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_BUFFER_FRAMES: buffer_frames_q <= cfg_data;
					REG_STREAM_MODE:   stream_mode_q   <= cfg_data[0];
					REG_LOOPING:       looping_q       <= cfg_data[0];
					default:           ;
				endcase
			end
			valid_s1 <= accept;
			if (accept) begin
				cursor_q    <= cursor_d;
				half_done_q <= half_done_d;
				playing_q   <= playing_d;
				hit_s1      <= hit_d;
				counted_s1  <= counted_d;
			end
		end
	end

	always_comb begin
		status.valid      = valid_s1;
		status.hit        = hit_s1;
		status.counted    = counted_s1;
		status.half0_done = half_done_q[0];
		status.half1_done = half_done_q[1];
		status.playing    = playing_q;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && hit_d && !looping_q && at_end) |=> !playing_q)
		else $error("end of region did not stop playback");
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && hit_d) |=> half_done_q[$past(idx)] || !$past(at_end) || status.hit)
		else $error("hit lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !playing_q) |=> !status.counted && $stable(cursor_q))
		else $error("stopped read advanced or counted");

endmodule
`default_nettype wire

### hdl/ping_pong_audio_buffer_reader.sv
// Top level: frame store memory, output stage and the playback control block.
// Depends on pbr_pkg and pbr_ctrl.
//
// channel   signals                                           handshake
// command   operation write_address frame_in half_select      start & !busy
// result    frame_out frame_counted half0/1_done is_playing   valid, one cycle
// config    cfg_index cfg_data                                cfg_we
//
// One command per cycle; its result appears in the cycle after the beat.
// The frame store is a 4096 x 32 synchronous memory read in the beat cycle.
// busy stays low; the receiver cannot stall, so results never back up.
// Reset clears control state and registers; the store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module ping_pong_audio_buffer_reader
	import pbr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [2:0]            operation,
	input  wire logic [ADDR_W-1:0]     write_address,
	input  wire logic [FRAME_BITS-1:0] frame_in,
	input  wire logic                  half_select,
	output logic                       valid,
	output logic [FRAME_BITS-1:0]      frame_out,
	output logic                       frame_counted,
	output logic                       half0_done,
	output logic                       half1_done,
	output logic                       is_playing,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data
);

	logic [FRAME_BITS-1:0] mem_q [STORE_DEPTH];
	logic [FRAME_BITS-1:0] rdata_s1;
	logic                  accept;
	logic                  wr_en;
	logic                  rd_en;
	logic [ADDR_W-1:0]     rd_addr;
	pbr_status_t           status;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign wr_en  = accept && (op_t'(operation) == OP_WRITE);

	pbr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.operation   (operation),
		.half_select (half_select),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.status      (status)
	);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[write_address] <= frame_in;
		end
		if (rd_en) begin
			rdata_s1 <= mem_q[rd_addr];
		end
	end

	assign valid         = status.valid;
	assign frame_out     = status.hit ? rdata_s1 : '0;
	assign frame_counted = status.counted;
	assign half0_done    = status.half0_done;
	assign half1_done    = status.half1_done;
	assign is_playing    = status.playing;

	assert property (@(posedge clk) disable iff (!arst_n) accept |=> valid)
		else $error("beat without result");
	assert property (@(posedge clk) disable iff (!arst_n) !accept |=> !valid)
		else $error("result without beat");
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid && status.hit) |-> frame_counted)
		else $error("stored frame returned uncounted");
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op_t'(operation) != OP_READ)) |=> !frame_counted && !status.hit)
		else $error("non-read beat returned a frame");

endmodule
`default_nettype wire

### tb/pbr_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the double-buffered playback frame store: mirrors the store, cursor,
// done flags and registers from the observed beats and checks every result strobe.
// Depends on pbr_pkg.
module pbr_checker
	import pbr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic                  busy,
	input  wire logic [2:0]            operation,
	input  wire logic [ADDR_W-1:0]     write_address,
	input  wire logic [FRAME_BITS-1:0] frame_in,
	input  wire logic                  half_select,
	input  wire logic                  valid,
	input  wire logic [FRAME_BITS-1:0] frame_out,
	input  wire logic                  frame_counted,
	input  wire logic                  half0_done,
	input  wire logic                  half1_done,
	input  wire logic                  is_playing,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	output int                         mismatches,
	output int                         outstanding
);

	typedef struct packed {
		logic [FRAME_BITS-1:0] frame;
		logic                  counted;
		logic                  h0_done;
		logic                  h1_done;
		logic                  playing;
	} playback_result_t;

	logic [FRAME_BITS-1:0] frames_held [STORE_DEPTH];
	int                    cursor;
	logic [1:0]            done_flags;
	logic                  playing_now;
	logic [CFG_W-1:0]      frames_cfg;
	logic                  stream_cfg;
	logic                  loop_cfg;
	playback_result_t      awaited [$];

	task automatic play_command(output playback_result_t res);
		int   size;
		int   half;
		int   idx;
		logic at_end;
		res = '0;
		case (operation)
		OP_WRITE: frames_held[write_address] = frame_in;
		OP_READ: if (playing_now) begin
			size = (frames_cfg > STORE_DEPTH) ? STORE_DEPTH : int'(frames_cfg);
			size = size & ~1;
			if (size < 2)
				size = 2;
			half = size / 2;
			if (cursor >= size) begin
				cursor = 0;
			end else begin
				idx = (cursor >= half) ? 1 : 0;
				res.counted = 1'b1;
				if (!(stream_cfg && done_flags[idx])) begin
					res.frame = frames_held[cursor];
					at_end = stream_cfg ? (cursor + 1 == half * (idx + 1)) : (cursor + 1 == size);
					cursor = (cursor + 1 >= size) ? 0 : cursor + 1;
					if (at_end) begin
						done_flags[idx] = 1'b1;
						if (!loop_cfg)
							playing_now = 1'b0;
					end
				end
			end
		end
		OP_RELEASE: done_flags[half_select] = 1'b0;
		OP_START: playing_now = 1'b1;
		OP_STOP: playing_now = 1'b0;
		default: ;
		endcase
		res.h0_done = done_flags[0];
		res.h1_done = done_flags[1];
		res.playing = playing_now;
	endtask

	always @(posedge clk or negedge arst_n) begin
		playback_result_t want;
		playback_result_t got;
		if (!arst_n) begin
			cursor = 0;
			done_flags = 2'b11;
			playing_now = 1'b0;
			frames_cfg = CFG_W'(STORE_DEPTH);
			stream_cfg = 1'b1;
			loop_cfg = 1'b0;
			awaited.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				REG_BUFFER_FRAMES: frames_cfg = cfg_data;
				REG_STREAM_MODE: stream_cfg = cfg_data[0];
				REG_LOOPING: loop_cfg = cfg_data[0];
				default: ;
				endcase
			end
			if (start && !busy) begin
				play_command(want);
				awaited.push_back(want);
			end
			if (valid) begin
				got.frame = frame_out;
				got.counted = frame_counted;
				got.h0_done = half0_done;
				got.h1_done = half1_done;
				got.playing = is_playing;
				if (awaited.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result with nothing awaited: frame %h counted %b",
							$realtime, frame_out, frame_counted);
					mismatches++;
				end else begin
					want = awaited.pop_front();
					if (got.frame !== want.frame || got.counted !== want.counted ||
						got.h0_done !== want.h0_done || got.h1_done !== want.h1_done ||
						got.playing !== want.playing) begin
						if (mismatches < 10)
							$display("%0t: frame %h/%h counted %b/%b done %b%b/%b%b playing %b/%b (exp/got)",
								$realtime, want.frame, got.frame, want.counted, got.counted,
								want.h1_done, want.h0_done, got.h1_done, got.h0_done,
								want.playing, got.playing);
						mismatches++;
					end
				end
			end
			outstanding = awaited.size();
		end
	end

endmodule

### tb/ping_pong_audio_buffer_reader_tb.sv
`timescale 1ns / 1ps
// Top of the playback frame store bench: clock, reset, command and register stimulus.
// Depends on pbr_pkg, pbr_checker and ping_pong_audio_buffer_reader.
module ping_pong_audio_buffer_reader_tb;
	import pbr_pkg::*;

	localparam logic [2:0] OP_SPARE5 = 3'd5;
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 18;
	localparam int PHASE_ITEMS = 62;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [2:0]            operation;
	logic [ADDR_W-1:0]     write_address;
	logic [FRAME_BITS-1:0] frame_in;
	logic                  half_select;
	logic                  valid;
	logic [FRAME_BITS-1:0] frame_out;
	logic                  frame_counted;
	logic                  half0_done;
	logic                  half1_done;
	logic                  is_playing;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;
	int                    mismatches;
	int                    outstanding;
	int                    cycles = 0;

	// written[] and fill keep every frame the cursor can reach written before a read
	bit written [STORE_DEPTH];
	int fill;
	int reach;
	int region;
	bit burst;

	int dir_frames [8] = '{2, 2, 0, 1, 7, 8191, 4096, 16};
	bit dir_stream [8] = '{1, 0, 1, 0, 1, 1, 0, 0};
	bit dir_loop   [8] = '{0, 1, 1, 0, 1, 0, 1, 0};

	ping_pong_audio_buffer_reader i_dut (
		.clk, .arst_n, .start, .busy, .operation, .write_address, .frame_in, .half_select,
		.valid, .frame_out, .frame_counted, .half0_done, .half1_done, .is_playing,
		.cfg_we, .cfg_index, .cfg_data
	);

	pbr_checker i_checker (
		.clk, .arst_n, .start, .busy, .operation, .write_address, .frame_in, .half_select,
		.valid, .frame_out, .frame_counted, .half0_done, .half1_done, .is_playing,
		.cfg_we, .cfg_index, .cfg_data, .mismatches, .outstanding
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send(input logic [2:0] op, input logic [ADDR_W-1:0] addr,
		input logic [FRAME_BITS-1:0] data, input logic hsel);
		int gap;
		bit taken;
		gap = burst ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		write_address <= addr;
		frame_in <= data;
		half_select <= hsel;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		if (op == OP_WRITE) begin
			written[addr] = 1'b1;
			while (fill < STORE_DEPTH && written[fill])
				fill++;
		end else if (op == OP_READ && reach < region) begin
			reach = (reach + 1 < region) ? reach + 1 : region - 1;
		end
	endtask

	// fill ahead of the furthest frame the cursor could point at
	task automatic send_read();
		while (reach >= fill)
			send(OP_WRITE, ADDR_W'(fill), $urandom, 1'($urandom));
		send(OP_READ, ADDR_W'($urandom), $urandom, 1'($urandom));
	endtask

	task automatic reconfigure(input int frames_val, input bit stream_on, input bit loop_on);
		start <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (2) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_BUFFER_FRAMES;
		cfg_data <= CFG_W'(frames_val);
		@(posedge clk);
		cfg_index <= REG_STREAM_MODE;
		cfg_data <= CFG_W'(stream_on);
		@(posedge clk);
		cfg_index <= REG_LOOPING;
		cfg_data <= CFG_W'(loop_on);
		@(posedge clk);
		cfg_we <= 1'b0;
		region = frames_val & 8191;
		if (region > STORE_DEPTH)
			region = STORE_DEPTH;
		region = region & ~1;
		if (region < 2)
			region = 2;
	endtask

	task automatic random_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			send_read();
		else if (pick < 62)
			send(OP_WRITE, ADDR_W'($urandom_range(0, STORE_DEPTH - 1)), $urandom, 1'($urandom));
		else if (pick < 76)
			send(OP_RELEASE, ADDR_W'($urandom), $urandom, 1'($urandom));
		else if (pick < 88)
			send(OP_START, ADDR_W'($urandom), $urandom, 1'($urandom));
		else if (pick < 94)
			send(OP_STOP, ADDR_W'($urandom), $urandom, 1'($urandom));
		else
			send(pick < 96 ? OP_SPARE5 : (pick < 98 ? OP_SPARE6 : OP_SPARE7),
				ADDR_W'($urandom), $urandom, 1'($urandom));
	endtask

	initial begin
		int p;
		arst_n <= 1'b0;
		start <= 1'b0;
		operation <= OP_WRITE;
		write_address <= '0;
		frame_in <= '0;
		half_select <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_BUFFER_FRAMES;
		cfg_data <= '0;
		fill = 0;
		reach = 0;
		region = STORE_DEPTH;
		burst = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_read();
		send(OP_SPARE5, '0, '0, 1'b0);
		send(OP_SPARE6, '1, '1, 1'b1);
		send(OP_SPARE7, '0, '1, 1'b0);
		send(OP_WRITE, ADDR_W'(STORE_DEPTH - 1), '1, 1'b1);
		send(OP_WRITE, '0, '0, 1'b0);
		send(OP_WRITE, ADDR_W'(1), 32'ha5a5_a5a5, 1'b0);
		send(OP_START, '0, '0, 1'b0);
		send_read();
		send(OP_RELEASE, '0, '0, 1'b0);
		send(OP_RELEASE, '0, '0, 1'b1);
		send_read();
		send_read();
		send(OP_STOP, '0, '0, 1'b0);
		send_read();
		send(OP_START, '0, '0, 1'b0);
		send_read();

		for (p = 0; p < PHASES; p++) begin
			if (p < 8)
				reconfigure(dir_frames[p], dir_stream[p], dir_loop[p]);
			else
				reconfigure(($urandom_range(0, 3) != 0) ? $urandom_range(2, 32)
					: $urandom_range(0, 8191), 1'($urandom), 1'($urandom));
			burst = ($urandom_range(0, 3) == 0);
			repeat (PHASE_ITEMS) random_item();
		end

		start <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
